[rtl/core/chunked_transfer_decoder_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the chunked transfer decoder
// Clocked checks with an asynchronous active-low reset as disable.
// ----------------------------------------------------------------------------
`ifndef CHUNKED_TRANSFER_DECODER_MACROS_SVH
`define CHUNKED_TRANSFER_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define CTD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ctd: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define CTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ctd: next-cycle check failed");

`endif

[rtl/core/ctd_pkg.sv]
// ----------------------------------------------------------------------------
// ctd_pkg
// Types and constants shared by the chunked transfer decoder modules.
// ----------------------------------------------------------------------------
package ctd_pkg;

	// Width of the chunk size accumulator
	localparam int SIZE_BITS = 32;

	localparam logic [15:0] MAX_LINE_RESET = 16'd4096;

	// Result status codes
	localparam logic [2:0] ST_FRAME   = 3'd0;
	localparam logic [2:0] ST_DATA    = 3'd1;
	localparam logic [2:0] ST_END     = 3'd2;
	localparam logic [2:0] ST_ERROR   = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;

	// Item operations
	localparam logic OP_CONSUME = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	typedef enum logic [3:0] {
		PH_SIZE     = 4'd0,
		PH_SIZE_WS  = 4'd1,
		PH_EXT_WS   = 4'd2,
		PH_EXT_UOB  = 4'd3,
		PH_EXT_IEOF = 4'd4,
		PH_EXT_NUM  = 4'd5,
		PH_EXT_SKIP = 4'd6,
		PH_SIZE_LF  = 4'd7,
		PH_DATA     = 4'd8,
		PH_DATA_CR  = 4'd9,
		PH_DATA_LF  = 4'd10,
		PH_FINAL_CR = 4'd11,
		PH_FINAL_LF = 4'd12,
		PH_DONE     = 4'd13,
		PH_ERROR    = 4'd14
	} phase_t;

	typedef struct packed {
		logic       op;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [7:0]         data_byte;
		logic               eof_flag;
		logic signed [31:0] original_body_offset;
		logic [31:0]        body_count;
	} out_item_t;

	// Parser state carried from item to item
	typedef struct packed {
		phase_t                phase;
		logic [SIZE_BITS-1:0]  chunk_remaining;
		logic [15:0]           line_length;
		logic                  digit_seen;
		logic [4:0]            match_index;
		logic [31:0]           offset;
		logic                  eof_mark;
		logic [31:0]           payload_counter;
	} ctd_state_t;

	localparam ctd_state_t STATE_RESET = '{
		phase:           PH_SIZE,
		chunk_remaining: '0,
		line_length:     16'd0,
		digit_seen:      1'b0,
		match_index:     5'd0,
		offset:          32'hFFFF_FFFF,
		eof_mark:        1'b0,
		payload_counter: 32'd0
	};

endpackage

[rtl/core/chunked_transfer_decoder.sv]
// An item is captured in the input register, then its result in the result
// register, which holds back the input stage while full and not drained.
// Throughput: one item per cycle while results are taken; the input stage
// advances when the result register is empty or drained in the same cycle.
// Reset: arst_n clears the parser state, both stage valids, and sets
// max_line_length to 4096; a restart item clears the parser state only.
// ----------------------------------------------------------------------------
// chunked_transfer_decoder
// Decodes an HTTP chunked body one byte per item, with an input register,
// a single-pass parser step, and a result register.
// ----------------------------------------------------------------------------
`include "chunked_transfer_decoder_macros.svh"

module chunked_transfer_decoder import ctd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  in_item_t    item,
	output logic        result_valid,
	input  logic        result_ready,
	output out_item_t   result,
	input  logic        wr_en,
	input  logic [15:0] wr_data
);

	in_item_t    item_s1;
	logic        item_valid_s1;
	out_item_t   result_s2;
	logic        result_valid_s2;
	ctd_state_t  state_q;
	logic [15:0] max_line_length_q;
	ctd_state_t  state_nxt;
	out_item_t   step_result;
	logic        advance;
	logic        take_consume;
	logic        take_restart;
	logic        at_end;
	logic        stage_stall;
	logic        in_data;

	// Move the input stage into the result register
	assign advance    = item_valid_s1 && (!result_valid_s2 || result_ready);
	assign item_ready = !item_valid_s1 || advance;

	// Hold the line length limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_line_length_q <= MAX_LINE_RESET;
		end else if (wr_en) begin
			max_line_length_q <= wr_data;
		end
	end

	// Capture an accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_ready) begin
			item_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	ctd_step u_step (
		.cur             (state_q),
		.item            (item_s1),
		.max_line_length (max_line_length_q),
		.nxt             (state_nxt),
		.result          (step_result)
	);

	// Update parser state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= STATE_RESET;
			result_valid_s2 <= 1'b0;
		end else if (advance) begin
			state_q         <= state_nxt;
			result_valid_s2 <= 1'b1;
		end else if (result_ready) begin
			result_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= step_result;
		end
	end

	assign result_valid = result_valid_s2;
	assign result       = result_s2;

	// Checks on the parser and the input stage
	assign take_consume = advance && (item_s1.op == OP_CONSUME);
	assign take_restart = advance && (item_s1.op == OP_RESTART);
	assign at_end       = (state_q.phase == PH_DONE) || (state_q.phase == PH_ERROR);
	assign stage_stall  = item_valid_s1 && !advance;
	assign in_data      = (state_q.phase == PH_DATA);

	`CTD_ASSERT_SAME(a_ignore_after_end, clk, arst_n, take_consume && at_end, step_result.status == ST_IGNORED)
	`CTD_ASSERT_NEXT(a_restart_clears, clk, arst_n, take_restart, state_q == STATE_RESET)
	`CTD_ASSERT_NEXT(a_stage_holds, clk, arst_n, stage_stall, item_valid_s1 && $stable(item_s1))
	`CTD_ASSERT_SAME(a_data_nonzero, clk, arst_n, in_data, state_q.chunk_remaining != '0)

endmodule

[rtl/core/ctd_step.sv]
// ----------------------------------------------------------------------------
// ctd_step
// Next-state and result logic for one byte of a chunked body.
// ----------------------------------------------------------------------------
module ctd_step import ctd_pkg::*; (
	input  ctd_state_t  cur,
	input  in_item_t    item,
	input  logic [15:0] max_line_length,
	output ctd_state_t  nxt,
	output out_item_t   result
);

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [4:0] UOB_LEN  = 5'd18;
	localparam logic [4:0] IEOF_LEN = 5'd4;
	localparam logic [35:0] OFFSET_MAX = 36'h0_7FFF_FFFF;
	localparam logic [SIZE_BITS-1:0] SIZE_ONE = {{(SIZE_BITS-1){1'b0}}, 1'b1};

	// Extension name "use-original-body="
	function automatic logic [7:0] uob_char(input logic [4:0] idx);
		case (idx)
			5'd0:    uob_char = "u";
			5'd1:    uob_char = "s";
			5'd2:    uob_char = "e";
			5'd3:    uob_char = "-";
			5'd4:    uob_char = "o";
			5'd5:    uob_char = "r";
			5'd6:    uob_char = "i";
			5'd7:    uob_char = "g";
			5'd8:    uob_char = "i";
			5'd9:    uob_char = "n";
			5'd10:   uob_char = "a";
			5'd11:   uob_char = "l";
			5'd12:   uob_char = "-";
			5'd13:   uob_char = "b";
			5'd14:   uob_char = "o";
			5'd15:   uob_char = "d";
			5'd16:   uob_char = "y";
			5'd17:   uob_char = "=";
			default: uob_char = 8'h00;
		endcase
	endfunction

	// Extension name "ieof"
	function automatic logic [7:0] ieof_char(input logic [4:0] idx);
		case (idx)
			5'd0:    ieof_char = "i";
			5'd1:    ieof_char = "e";
			5'd2:    ieof_char = "o";
			5'd3:    ieof_char = "f";
			default: ieof_char = 8'h00;
		endcase
	endfunction

	logic [7:0]           c;
	logic                 is_dec;
	logic                 is_hex;
	logic [3:0]           hex_val;
	logic                 is_blank;
	logic [15:0]          line_inc;
	logic                 line_too_long;
	logic [SIZE_BITS-1:0] rem_dec;
	logic [SIZE_BITS-1:0] rem_shift;
	logic                 rem_full;
	logic                 rem_zero;
	logic [35:0]          off_prod;
	logic [31:0]          off_sat;
	logic [4:0]           match_inc;
	phase_t               ws_phase;
	phase_t               skip_phase;
	logic [2:0]           status;
	logic [7:0]           data;

	assign c        = item.in_byte;
	assign is_dec   = (c inside {[8'h30:8'h39]});
	assign is_blank = (c == CH_SP) || (c == CH_TAB);

	// Decode a hex digit
	always_comb begin
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (is_dec) begin
			hex_val = c[3:0];
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			hex_val = 4'(c[2:0] + 3'd1) + 4'd8;
		end else begin
			is_hex = 1'b0;
		end
	end

	// Line length, saturating at its maximum
	assign line_inc      = (cur.line_length != 16'hFFFF) ? cur.line_length + 16'd1
		: cur.line_length;
	assign line_too_long = line_inc > max_line_length;

	assign rem_dec   = cur.chunk_remaining - SIZE_ONE;
	assign rem_shift = {cur.chunk_remaining[SIZE_BITS-5:0], hex_val};
	assign rem_full  = cur.chunk_remaining[SIZE_BITS-1 -: 4] != 4'd0;
	assign rem_zero  = cur.chunk_remaining == '0;
	assign match_inc = cur.match_index + 5'd1;

	// Offset times ten plus digit, saturating at the largest positive value
	assign off_prod = {1'b0, cur.offset, 3'b000} + {3'b000, cur.offset, 1'b0}
		+ {32'd0, c[3:0]};
	assign off_sat  = (off_prod > OFFSET_MAX) ? OFFSET_MAX[31:0] : off_prod[31:0];

	// Phase after a byte that ends the size digits
	always_comb begin
		if (is_blank) begin
			ws_phase = PH_SIZE_WS;
		end else if (c == CH_CR) begin
			ws_phase = PH_SIZE_LF;
		end else if (c == CH_SEMI && rem_zero) begin
			ws_phase = PH_EXT_WS;
		end else begin
			ws_phase = PH_ERROR;
		end
	end

	assign skip_phase = (c == CH_CR) ? PH_SIZE_LF : PH_EXT_SKIP;

	// Advance the parser by one byte
	always_comb begin
		nxt    = cur;
		status = ST_FRAME;
		data   = 8'd0;
		if (item.op == OP_RESTART) begin
			nxt = STATE_RESET;
		end else begin
			case (cur.phase)
				PH_DONE, PH_ERROR: begin
					status = ST_IGNORED;
				end
				PH_DATA: begin
					status              = ST_DATA;
					data                = c;
					nxt.payload_counter = cur.payload_counter + 32'd1;
					nxt.chunk_remaining = rem_dec;
					if (rem_dec == '0) begin
						nxt.phase = PH_DATA_CR;
					end
				end
				PH_DATA_CR: begin
					nxt.phase = (c == CH_CR) ? PH_DATA_LF : PH_ERROR;
				end
				PH_DATA_LF: begin
					if (c == CH_LF) begin
						nxt.phase           = PH_SIZE;
						nxt.chunk_remaining = '0;
						nxt.line_length     = 16'd0;
						nxt.digit_seen      = 1'b0;
						nxt.match_index     = 5'd0;
					end else begin
						nxt.phase = PH_ERROR;
					end
				end
				PH_FINAL_CR: begin
					nxt.phase = (c == CH_CR) ? PH_FINAL_LF : PH_ERROR;
				end
				PH_FINAL_LF: begin
					if (c == CH_LF) begin
						nxt.phase = PH_DONE;
						status    = ST_END;
					end else begin
						nxt.phase = PH_ERROR;
					end
				end
				PH_SIZE, PH_SIZE_WS, PH_EXT_WS, PH_EXT_UOB, PH_EXT_IEOF,
				PH_EXT_NUM, PH_EXT_SKIP, PH_SIZE_LF: begin
					nxt.line_length = line_inc;
					if (line_too_long) begin
						nxt.phase = PH_ERROR;
					end else begin
						case (cur.phase)
							PH_SIZE: begin
								if (is_hex) begin
									if (rem_full) begin
										nxt.phase = PH_ERROR;
									end else begin
										nxt.chunk_remaining = rem_shift;
										nxt.digit_seen      = 1'b1;
									end
								end else if (!cur.digit_seen) begin
									nxt.phase = PH_ERROR;
								end else begin
									nxt.phase = ws_phase;
								end
							end
							PH_SIZE_WS: begin
								nxt.phase = ws_phase;
							end
							PH_EXT_WS: begin
								if (!is_blank) begin
									nxt.match_index = 5'd1;
									if (c == uob_char(5'd0)) begin
										nxt.phase = PH_EXT_UOB;
									end else if (c == ieof_char(5'd0)) begin
										nxt.phase = PH_EXT_IEOF;
									end else begin
										nxt.phase = PH_ERROR;
									end
								end
							end
							PH_EXT_UOB: begin
								if (cur.match_index >= UOB_LEN
									|| c != uob_char(cur.match_index)) begin
									nxt.phase = PH_ERROR;
								end else begin
									nxt.match_index = match_inc;
									if (match_inc == UOB_LEN) begin
										nxt.eof_mark = 1'b1;
										nxt.offset   = 32'd0;
										nxt.phase    = PH_EXT_NUM;
									end
								end
							end
							PH_EXT_IEOF: begin
								if (cur.match_index >= IEOF_LEN
									|| c != ieof_char(cur.match_index)) begin
									nxt.phase = PH_ERROR;
								end else begin
									nxt.match_index = match_inc;
									if (match_inc == IEOF_LEN) begin
										nxt.eof_mark = 1'b1;
										nxt.phase    = PH_EXT_SKIP;
									end
								end
							end
							PH_EXT_NUM: begin
								if (is_dec) begin
									nxt.offset = off_sat;
								end else begin
									nxt.phase = skip_phase;
								end
							end
							PH_EXT_SKIP: begin
								nxt.phase = skip_phase;
							end
							PH_SIZE_LF: begin
								if (c != CH_LF) begin
									nxt.phase = PH_ERROR;
								end else begin
									nxt.phase = rem_zero ? PH_FINAL_CR : PH_DATA;
								end
							end
							default: begin
								nxt.phase = PH_ERROR;
							end
						endcase
					end
				end
				default: begin
					nxt.phase = PH_ERROR;
				end
			endcase
		end
		if (nxt.phase == PH_ERROR && status == ST_FRAME) begin
			status = ST_ERROR;
		end
	end

	// Pack the result item
	always_comb begin
		result.status               = status;
		result.data_byte            = data;
		result.eof_flag             = nxt.eof_mark;
		result.original_body_offset = signed'(nxt.offset);
		result.body_count           = nxt.payload_counter;
	end

endmodule

[verif/chunked_transfer_decoder_test.sv]
// ----------------------------------------------------------------------------
// chunked_transfer_decoder_test
// Drives whole chunked bodies, some well formed and some broken, one byte per
// item, and checks every result against an in-bench parser model. The line
// limit register is swept between runs, and both handshakes are stalled.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder_test;
	import ctd_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 300;

	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	localparam logic [8*18-1:0] UOB_NAME  = "use-original-body=";
	localparam logic [8*4-1:0]  IEOF_NAME = "ieof";

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	in_item_t    item;
	logic        result_valid;
	logic        result_ready;
	out_item_t   result;
	logic        wr_en;
	logic [15:0] wr_data;

	// parser model state
	phase_t               dec_phase;
	logic [SIZE_BITS-1:0] size_left;
	logic [15:0]          line_len;
	logic                 hex_seen;
	logic [4:0]           name_pos;
	logic [31:0]          offset_val;
	logic                 eof_seen;
	logic [31:0]          payload_total;
	logic [15:0]          line_limit;

	out_item_t   pending_results[$];
	logic [7:0]  msg_bytes[$];

	int errors;
	int results_seen;
	int quiet_cycles;
	bit tx_jitter;
	bit rx_jitter;
	bit long_hold_req;
	int rx_hold;

	chunked_transfer_decoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.wr_en        (wr_en),
		.wr_data      (wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------

	function automatic void clear_message();
		dec_phase     = PH_SIZE;
		size_left     = '0;
		line_len      = 16'd0;
		hex_seen      = 1'b0;
		name_pos      = 5'd0;
		offset_val    = 32'hFFFF_FFFF;
		eof_seen      = 1'b0;
		payload_total = 32'd0;
	endfunction

	function automatic int hex_digit(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	// Advance the size line by one byte and return the next phase
	function automatic phase_t size_line_step(logic [7:0] c);
		int h;
		longint unsigned v;
		if (line_len != 16'hFFFF) line_len++;
		if (line_len > line_limit) return PH_ERROR;
		h = hex_digit(c);
		case (dec_phase)
			PH_SIZE, PH_SIZE_WS: begin
				if (dec_phase == PH_SIZE) begin
					if (h >= 0) begin
						if (size_left[SIZE_BITS-1 -: 4] != 4'd0) return PH_ERROR;
						size_left = {size_left[SIZE_BITS-5:0], h[3:0]};
						hex_seen = 1'b1;
						return PH_SIZE;
					end
					if (!hex_seen) return PH_ERROR;
				end
				// size digits are done: blanks, CR or an extension may follow
				if (c == CH_SP || c == CH_TAB) return PH_SIZE_WS;
				if (c == CH_CR) return PH_SIZE_LF;
				if (c == CH_SEMI && size_left == 0) return PH_EXT_WS;
				return PH_ERROR;
			end
			PH_EXT_WS: begin
				if (c == CH_SP || c == CH_TAB) return PH_EXT_WS;
				name_pos = 5'd1;
				if (c == UOB_NAME[8*17 +: 8]) return PH_EXT_UOB;
				if (c == IEOF_NAME[8*3 +: 8]) return PH_EXT_IEOF;
				return PH_ERROR;
			end
			PH_EXT_UOB: begin
				if (name_pos >= 18 || c != UOB_NAME[8*(17-name_pos) +: 8]) return PH_ERROR;
				name_pos++;
				if (name_pos == 18) begin
					eof_seen = 1'b1;
					offset_val = 32'd0;
					return PH_EXT_NUM;
				end
				return PH_EXT_UOB;
			end
			PH_EXT_IEOF: begin
				if (name_pos >= 4 || c != IEOF_NAME[8*(3-name_pos) +: 8]) return PH_ERROR;
				name_pos++;
				if (name_pos == 4) begin
					eof_seen = 1'b1;
					return PH_EXT_SKIP;
				end
				return PH_EXT_IEOF;
			end
			PH_EXT_NUM, PH_EXT_SKIP: begin
				// decimal offset, saturating at the largest positive value
				if (dec_phase == PH_EXT_NUM && c >= "0" && c <= "9") begin
					v = 64'(offset_val) * 64'd10 + 64'(c - "0");
					offset_val = (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
					return PH_EXT_NUM;
				end
				return (c == CH_CR) ? PH_SIZE_LF : PH_EXT_SKIP;
			end
			default: begin
				if (c != CH_LF) return PH_ERROR;
				return (size_left == 0) ? PH_FINAL_CR : PH_DATA;
			end
		endcase
	endfunction

	// Decode one item and return the result it must produce
	function automatic out_item_t decode_byte(in_item_t it);
		out_item_t  r;
		logic [2:0] st;
		logic [7:0] d;
		logic [7:0] c;
		st = ST_FRAME;
		d  = 8'd0;
		c  = it.in_byte;
		if (it.op == OP_RESTART) begin
			clear_message();
		end else if (dec_phase == PH_DONE || dec_phase == PH_ERROR) begin
			st = ST_IGNORED;
		end else begin
			case (dec_phase)
				PH_DATA: begin
					st = ST_DATA;
					d  = c;
					payload_total++;
					size_left--;
					if (size_left == 0) dec_phase = PH_DATA_CR;
				end
				PH_DATA_CR: dec_phase = (c == CH_CR) ? PH_DATA_LF : PH_ERROR;
				PH_DATA_LF: begin
					if (c == CH_LF) begin
						dec_phase = PH_SIZE;
						size_left = '0;
						line_len  = 16'd0;
						hex_seen  = 1'b0;
						name_pos  = 5'd0;
					end else begin
						dec_phase = PH_ERROR;
					end
				end
				PH_FINAL_CR: dec_phase = (c == CH_CR) ? PH_FINAL_LF : PH_ERROR;
				PH_FINAL_LF: begin
					if (c == CH_LF) begin
						dec_phase = PH_DONE;
						st = ST_END;
					end else begin
						dec_phase = PH_ERROR;
					end
				end
				default: dec_phase = size_line_step(c);
			endcase
		end
		if (dec_phase == PH_ERROR && st == ST_FRAME) st = ST_ERROR;
		r.status               = st;
		r.data_byte            = d;
		r.eof_flag             = eof_seen;
		r.original_body_offset = offset_val;
		r.body_count           = payload_total;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Checking and watchdog
	// ------------------------------------------------------------------

	task automatic report(input string msg);
		errors++;
		$display("%0t: %s", $time, msg);
	endtask

	always @(posedge clk) begin : check_results
		out_item_t want;
		bit        moved;
		if (arst_n) begin
			moved = 1'b0;
			// predict on input acceptance
			if (item_valid && item_ready) begin
				pending_results.push_back(decode_byte(item));
				moved = 1'b1;
			end
			// compare on output acceptance
			if (result_valid && result_ready) begin
				moved = 1'b1;
				if (pending_results.size() == 0) begin
					report($sformatf("result %0d arrived with none pending", results_seen));
				end else begin
					want = pending_results.pop_front();
					if (result.status !== want.status)
						report($sformatf("result %0d: status %0d, expected %0d",
							results_seen, result.status, want.status));
					if (result.data_byte !== want.data_byte)
						report($sformatf("result %0d: data_byte %0h, expected %0h",
							results_seen, result.data_byte, want.data_byte));
					if (result.eof_flag !== want.eof_flag)
						report($sformatf("result %0d: eof_flag %0b, expected %0b",
							results_seen, result.eof_flag, want.eof_flag));
					if (result.original_body_offset !== want.original_body_offset)
						report($sformatf("result %0d: original_body_offset %0d, expected %0d",
							results_seen, result.original_body_offset,
							want.original_body_offset));
					if (result.body_count !== want.body_count)
						report($sformatf("result %0d: body_count %0d, expected %0d",
							results_seen, result.body_count, want.body_count));
				end
				results_seen++;
			end
			quiet_cycles = moved ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no handshake for %0d cycles", QUIET_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side: random stall bursts and one long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				result_ready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				rx_hold = LONG_HOLD - 1;
				result_ready <= 1'b0;
			end else if (rx_jitter && $urandom_range(0, 15) == 0) begin
				rx_hold = $urandom_range(0, 16);
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Offer one item; called and returning at a falling edge
	task automatic send_item(input logic op, input logic [7:0] b);
		if (tx_jitter && $urandom_range(0, 9) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= '{op: op, in_byte: b};
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	task automatic send_message();
		send_item(OP_RESTART, 8'($urandom_range(0, 255)));
		foreach (msg_bytes[i]) send_item(OP_CONSUME, msg_bytes[i]);
	endtask

	// Drop valid and wait for the block to drain
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_line_limit(input logic [15:0] v);
		line_limit = v;
		wr_en   <= 1'b1;
		wr_data <= v;
		@(negedge clk);
		wr_en   <= 1'b0;
	endtask

	function automatic logic [7:0] hex_char(logic [3:0] nib, bit upper);
		if (nib < 10) return 8'h30 + nib;
		return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
	endfunction

	function automatic void push_str(string s);
		for (int i = 0; i < s.len(); i++) msg_bytes.push_back(s[i]);
	endfunction

	function automatic void push_crlf();
		msg_bytes.push_back(CH_CR);
		msg_bytes.push_back(CH_LF);
	endfunction

	function automatic void push_blanks(int n);
		repeat (n) msg_bytes.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
	endfunction

	function automatic void push_hex(int unsigned n, int unsigned zeros);
		bit upper;
		int top;
		upper = 1'($urandom_range(0, 1));
		repeat (zeros) msg_bytes.push_back("0");
		top = 7;
		while (top > 0 && n[4*top +: 4] == 4'd0) top--;
		for (int i = top; i >= 0; i--) msg_bytes.push_back(hex_char(n[4*i +: 4], upper));
	endfunction

	// Build one body: mostly well formed, some broken or pure noise
	function automatic void build_message();
		int unsigned size;
		int          kind;
		int          mode;
		logic [7:0]  b;
		msg_bytes.delete();
		mode = $urandom_range(0, 99);
		if (mode < 8) begin
			// noise
			repeat ($urandom_range(4, 16)) msg_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if (mode < 14) begin
			// size that runs past the accumulator width
			push_hex($urandom | 32'h1000_0000, $urandom_range(0, 2));
			msg_bytes.push_back(hex_char(4'($urandom_range(0, 15)),
				1'($urandom_range(0, 1))));
			push_crlf();
			return;
		end
		repeat ($urandom_range(0, 3)) begin
			size = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 300) : $urandom_range(1, 6);
			push_hex(size, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0);
			push_blanks($urandom_range(0, 2));
			push_crlf();
			repeat (size) msg_bytes.push_back(8'($urandom_range(0, 255)));
			push_crlf();
		end
		// last chunk, with an optional extension
		push_hex(0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0);
		push_blanks($urandom_range(0, 1));
		kind = $urandom_range(0, 2);
		if (kind != 0) begin
			msg_bytes.push_back(CH_SEMI);
			push_blanks($urandom_range(0, 2));
			if (kind == 1) begin
				push_str("ieof");
			end else begin
				push_str("use-original-body=");
				repeat ($urandom_range(0, 12))
					msg_bytes.push_back(8'("0" + $urandom_range(0, 9)));
			end
			repeat ($urandom_range(0, 3)) begin
				do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
				msg_bytes.push_back(b);
			end
		end
		push_crlf();
		push_crlf();
		repeat ($urandom_range(0, 2)) msg_bytes.push_back(8'($urandom_range(0, 255)));
		// break some of them
		if (mode < 30) begin
			msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (mode < 38) begin
			size = $urandom_range(0, msg_bytes.size() - 1);
			while (msg_bytes.size() > size) void'(msg_bytes.pop_back());
		end
	endfunction

	task automatic run_messages(input int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			build_message();
			send_message();
			sent += msg_bytes.size() + 1;
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Short directed bodies: one full body and three framing errors
	task automatic test_directed();
		// full body: one data chunk with an all-ones byte, ieof last chunk,
		// then a zero byte that must be ignored
		msg_bytes.delete();
		push_str("1");
		push_crlf();
		msg_bytes.push_back(8'hFF);
		push_crlf();
		push_str("0;ieof");
		push_crlf();
		push_crlf();
		msg_bytes.push_back(8'h00);
		send_message();
		// blank before the first hex digit
		msg_bytes = '{CH_TAB};
		send_message();
		// extension on a nonzero chunk
		msg_bytes = '{"1", CH_SEMI};
		send_message();
		// empty extension
		msg_bytes = '{"0", CH_SEMI, CH_CR};
		send_message();
	endtask

	task automatic test_line_limit(input logic [15:0] v, input int budget);
		wait_idle();
		set_line_limit(v);
		run_messages(budget);
	endtask

	// Hold off the result side while the sender keeps offering items
	task automatic test_backpressure();
		tx_jitter = 1'b0;
		long_hold_req = 1'b1;
		run_messages(150);
		tx_jitter = 1'b1;
	endtask

	// Back-to-back items on both sides with the reset line limit
	task automatic test_streaming();
		wait_idle();
		set_line_limit(MAX_LINE_RESET);
		tx_jitter = 1'b0;
		rx_jitter = 1'b0;
		run_messages(300);
	endtask

	initial begin
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		item          = '0;
		result_ready  = 1'b0;
		wr_en         = 1'b0;
		wr_data       = 16'd0;
		errors        = 0;
		results_seen  = 0;
		quiet_cycles  = 0;
		tx_jitter     = 1'b1;
		rx_jitter     = 1'b1;
		long_hold_req = 1'b0;
		rx_hold       = 0;
		line_limit    = MAX_LINE_RESET;
		clear_message();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_line_limit(16'd16, 150);
		test_line_limit(16'd65535, 250);
		test_line_limit(16'($urandom_range(17, 48)), 300);
		test_backpressure();
		test_streaming();

		// drain and let the pipeline settle
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[chunked_transfer_decoder.f]
+incdir+rtl/core
rtl/core/ctd_pkg.sv
rtl/core/ctd_step.sv
rtl/core/chunked_transfer_decoder.sv
verif/chunked_transfer_decoder_test.sv
